### rtl/rssc_pkg.sv
// Shared types and constants of the rotation synced slice scanner.
package rssc_pkg;

  localparam int MAX_SLICES_DEF = 64;
  localparam int LED_COUNT_DEF  = 32;
  localparam int TIME_BITS_DEF  = 32;

  localparam logic [6:0] SLICES_RESET = 7'd20;

  localparam int CMD_DEPTH = 2;
  localparam int OQ_DEPTH  = 4;
  localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_EDGE  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_EDGE,
    OP_WRITE
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_CHECK,
    ST_RUN
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [5:0]  slice;
    logic [4:0]  led;
    logic [23:0] color;
  } cmd_t;

  typedef struct packed {
    logic [4:0]  led_index;
    logic [23:0] pixel_color;
    logic [5:0]  shown_slice;
    logic        is_blank;
    logic        run_last;
  } res_t;

endpackage

### rtl/rssc_ram.sv
// Generic simple dual port RAM with registered read.
module rssc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rssc_fifo.sv
// Small flip-flop queue with occupancy count.
module rssc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic [CNT_W-1:0] count_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

### rtl/rssc_front.sv
// Front end: takes input requests, sorts them into commands and queues them.
module rssc_front import rssc_pkg::*; #(
  parameter int MAX_SLICES = MAX_SLICES_DEF,
  parameter int LED_COUNT  = LED_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind_i,
  input  logic [5:0]  write_slice_i,
  input  logic [4:0]  write_led_i,
  input  logic [23:0] write_color_i,
  input  logic        clearing_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_pop_i
);

  cmd_t cmd_in;
  logic keep, q_full, q_empty;

  // Unused kind and out-of-range writes are taken and dropped.
  always_comb begin
    cmd_in.slice = write_slice_i;
    cmd_in.led   = write_led_i;
    cmd_in.color = write_color_i;
    cmd_in.op    = OP_TICK;
    keep         = 1'b0;
    case (kind_i)
      KIND_TICK: begin
        cmd_in.op = OP_TICK;
        keep      = 1'b1;
      end
      KIND_EDGE: begin
        cmd_in.op = OP_EDGE;
        keep      = 1'b1;
      end
      KIND_WRITE: begin
        cmd_in.op = OP_WRITE;
        keep      = (int'(write_slice_i) < MAX_SLICES) && (int'(write_led_i) < LED_COUNT);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full        = q_full || clearing_i;
  assign cmd_valid_o = !q_empty;

  rssc_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push && !full && keep),
    .wdata_i(cmd_in),
    .full_o (q_full),
    .pop_i  (cmd_pop_i),
    .rdata_o(cmd_o),
    .empty_o(q_empty),
    .count_o()
  );

endmodule

### rtl/rssc_back.sv
// Back end: time keeping, serial slice division, store access and pixel runs.
module rssc_back import rssc_pkg::*; #(
  parameter int MAX_SLICES = MAX_SLICES_DEF,
  parameter int LED_COUNT  = LED_COUNT_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF,
  localparam int STORE_DEPTH = MAX_SLICES * LED_COUNT,
  localparam int ADDR_BITS   = $clog2(STORE_DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [6:0]           slices_i,
  output logic                 clearing_o,
  input  logic                 cmd_valid_i,
  input  cmd_t                 cmd_i,
  output logic                 cmd_pop_o,
  output logic                 ram_we_o,
  output logic [ADDR_BITS-1:0] ram_waddr_o,
  output logic [23:0]          ram_wdata_o,
  output logic [ADDR_BITS-1:0] ram_raddr_o,
  input  logic [23:0]          ram_rdata_i,
  input  logic [OQ_CNT_W-1:0]  oq_count_i,
  output logic                 res_valid_o,
  output res_t                 res_o
);

  localparam int MULT_BITS  = $clog2(MAX_SLICES + 1);
  localparam int SLICE_BITS = $clog2(MAX_SLICES);
  localparam int BIT_W      = $clog2(MULT_BITS);
  localparam int EFF_W      = (MULT_BITS > 7) ? MULT_BITS : 7;
  localparam int LED_W      = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  state_e                state_q, state_d;
  logic [TIME_BITS-1:0]  now_q, now_d, last_q, last_d, period_q, period_d;
  logic [TIME_BITS-1:0]  num_q, num_d, rem_q, rem_d, elapsed;
  logic [TIME_BITS:0]    dbl, sum;
  logic [MULT_BITS-1:0]  quo_q, quo_d, eff_q, eff_d;
  logic [EFF_W-1:0]      cfg_ext, max_ext, eff_sat;
  logic [BIT_W-1:0]      bit_q, bit_d;
  logic                  phase_q, phase_d;
  logic                  shown_valid_q, shown_valid_d;
  logic [SLICE_BITS-1:0] shown_idx_q, shown_idx_d, run_slice_q, run_slice_d;
  logic                  run_blank_q, run_blank_d;
  logic [ADDR_BITS-1:0]  clr_q, clr_d, base_q, base_d;
  logic [LED_W-1:0]      led_q, led_d;
  logic                  issue, led_last;
  logic                  pend_q;
  logic [LED_W-1:0]      pend_led_q;
  logic [SLICE_BITS-1:0] pend_slice_q;
  logic                  pend_blank_q, pend_last_q;

  assign elapsed  = now_q - last_q;
  assign cfg_ext  = EFF_W'(slices_i);
  assign max_ext  = EFF_W'(MAX_SLICES);
  assign eff_sat  = (cfg_ext > max_ext) ? max_ext : cfg_ext;
  assign led_last = (led_q == LED_W'(LED_COUNT - 1));
  // Room in the result queue for this read and the one still in flight.
  assign issue    = (state_q == ST_RUN) &&
                    (({1'b0, oq_count_i} + (OQ_CNT_W + 1)'(pend_q)) <
                     (OQ_CNT_W + 1)'(OQ_DEPTH));

  assign clearing_o  = (state_q == ST_CLEAR);
  assign ram_raddr_o = base_q + ADDR_BITS'(led_q);

  always_comb begin
    state_d       = state_q;
    now_d         = now_q;
    last_d        = last_q;
    period_d      = period_q;
    num_d         = num_q;
    rem_d         = rem_q;
    quo_d         = quo_q;
    eff_d         = eff_q;
    bit_d         = bit_q;
    phase_d       = phase_q;
    shown_valid_d = shown_valid_q;
    shown_idx_d   = shown_idx_q;
    run_slice_d   = run_slice_q;
    run_blank_d   = run_blank_q;
    clr_d         = clr_q;
    base_d        = base_q;
    led_d         = led_q;
    cmd_pop_o     = 1'b0;
    ram_we_o      = 1'b0;
    ram_waddr_o   = ADDR_BITS'(cmd_i.slice) * ADDR_BITS'(LED_COUNT) + ADDR_BITS'(cmd_i.led);
    ram_wdata_o   = cmd_i.color;
    dbl           = {rem_q, 1'b0};
    sum           = {1'b0, rem_q} + {1'b0, num_q};
    case (state_q)
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = '0;
        clr_d       = clr_q + 1'b1;
        if (clr_q == ADDR_BITS'(STORE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            OP_TICK: begin
              now_d   = now_q + 1'b1;
              state_d = ST_EVAL;
            end
            OP_EDGE: begin
              period_d = now_q - last_q;
              last_d   = now_q;
              state_d  = ST_EVAL;
            end
            OP_WRITE: begin
              ram_we_o = 1'b1;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_EVAL: begin
        state_d = ST_IDLE;
        if (period_q != '0) begin
          if (elapsed >= period_q) begin
            // Rotation stopped: blank once after something was shown.
            if (shown_valid_q) begin
              shown_valid_d = 1'b0;
              run_blank_d   = 1'b1;
              run_slice_d   = '0;
              base_d        = '0;
              led_d         = '0;
              state_d       = ST_RUN;
            end
          end else if (eff_sat != '0) begin
            eff_d   = MULT_BITS'(eff_sat);
            num_d   = elapsed;
            rem_d   = '0;
            quo_d   = '0;
            bit_d   = BIT_W'(MULT_BITS - 1);
            phase_d = 1'b0;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        // Remainder stays below the period; doubling then adding per bit.
        if (!phase_q) begin
          if (dbl >= {1'b0, period_q}) begin
            rem_d = TIME_BITS'(dbl - {1'b0, period_q});
            quo_d = {quo_q[MULT_BITS-2:0], 1'b1};
          end else begin
            rem_d = TIME_BITS'(dbl);
            quo_d = {quo_q[MULT_BITS-2:0], 1'b0};
          end
          phase_d = 1'b1;
        end else begin
          if (eff_q[bit_q]) begin
            if (sum >= {1'b0, period_q}) begin
              rem_d = TIME_BITS'(sum - {1'b0, period_q});
              quo_d = quo_q + 1'b1;
            end else begin
              rem_d = TIME_BITS'(sum);
            end
          end
          phase_d = 1'b0;
          if (bit_q == '0) begin
            state_d = ST_CHECK;
          end else begin
            bit_d = bit_q - 1'b1;
          end
        end
      end
      ST_CHECK: begin
        state_d = ST_IDLE;
        if (quo_q < eff_q) begin
          if (!(shown_valid_q && (quo_q[SLICE_BITS-1:0] == shown_idx_q))) begin
            shown_valid_d = 1'b1;
            shown_idx_d   = quo_q[SLICE_BITS-1:0];
            run_slice_d   = quo_q[SLICE_BITS-1:0];
            run_blank_d   = 1'b0;
            base_d        = ADDR_BITS'(quo_q[SLICE_BITS-1:0]) * ADDR_BITS'(LED_COUNT);
            led_d         = '0;
            state_d       = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (issue) begin
          led_d = led_q + 1'b1;
          if (led_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      now_q         <= '0;
      last_q        <= '0;
      period_q      <= '0;
      shown_valid_q <= 1'b0;
      shown_idx_q   <= '0;
      clr_q         <= '0;
      phase_q       <= 1'b0;
      bit_q         <= '0;
      led_q         <= '0;
      pend_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      now_q         <= now_d;
      last_q        <= last_d;
      period_q      <= period_d;
      shown_valid_q <= shown_valid_d;
      shown_idx_q   <= shown_idx_d;
      clr_q         <= clr_d;
      phase_q       <= phase_d;
      bit_q         <= bit_d;
      led_q         <= led_d;
      pend_q        <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q       <= num_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    eff_q       <= eff_d;
    run_slice_q <= run_slice_d;
    run_blank_q <= run_blank_d;
    base_q      <= base_d;
    if (issue) begin
      pend_led_q   <= led_q;
      pend_slice_q <= run_slice_q;
      pend_blank_q <= run_blank_q;
      pend_last_q  <= led_last;
    end
  end

  // Read data lands in the cycle after issue and goes straight to the queue.
  assign res_valid_o       = pend_q;
  assign res_o.led_index   = 5'(pend_led_q);
  assign res_o.pixel_color = pend_blank_q ? 24'd0 : ram_rdata_i;
  assign res_o.shown_slice = 6'(pend_slice_q);
  assign res_o.is_blank    = pend_blank_q;
  assign res_o.run_last    = pend_last_q;

endmodule

### rtl/rotation_synced_slice_scanner.sv
// Top level of the rotation synced slice scanner for a spinning LED strip.
//
// Requests come in through a queue-like port: a request is taken when push is
// high and full is low. kind selects a millisecond tick, a hall sensor edge or
// a pixel write into the polar image store (write_slice, write_led,
// write_color). Results leave through a second queue-like port: the oldest
// pixel sits on the result ports while empty is low and is taken with pop.
// Each run is LED_COUNT pixels, run_last marks its final pixel; a blank run
// carries zero colour and is_blank set.
// slices_in_use is written through cfg_we_i/cfg_wdata_i; the user must write
// it only while the block idles, the block itself does not enforce this.
// After reset the image store is swept to black, one entry per cycle, over all
// MAX_SLICES*LED_COUNT entries (2048 by default); full stays high meanwhile.
// A pixel write is stored by the back end from its idle state. A tick or edge
// is evaluated and may pass the serial slice divider (a doubling and an adding
// step per quotient bit) and a check, then a run of LED_COUNT pixels, one store
// read per pixel. A two-entry request queue decouples intake from the back end;
// a four-entry result queue absorbs receiver stalls, and a run pauses while full.
module rotation_synced_slice_scanner import rssc_pkg::*; #(
  parameter int MAX_SLICES = MAX_SLICES_DEF,
  parameter int LED_COUNT  = LED_COUNT_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind_i,
  input  logic [5:0]  write_slice_i,
  input  logic [4:0]  write_led_i,
  input  logic [23:0] write_color_i,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  led_index_o,
  output logic [23:0] pixel_color_o,
  output logic [5:0]  shown_slice_o,
  output logic        is_blank_o,
  output logic        run_last_o
);

  localparam int STORE_DEPTH = MAX_SLICES * LED_COUNT;
  localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

  logic [6:0]           slices_q;
  logic                 clearing;
  logic                 cmd_valid, cmd_pop;
  cmd_t                 cmd;
  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_waddr, ram_raddr;
  logic [23:0]          ram_wdata, ram_rdata;
  logic [OQ_CNT_W-1:0]  oq_count;
  logic                 res_valid;
  res_t                 res, res_head;

  // Slice count register; saturation to MAX_SLICES happens in the back end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slices_q <= SLICES_RESET;
    end else if (cfg_we_i) begin
      slices_q <= cfg_wdata_i;
    end
  end

  rssc_front #(
    .MAX_SLICES(MAX_SLICES),
    .LED_COUNT (LED_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .kind_i       (kind_i),
    .write_slice_i(write_slice_i),
    .write_led_i  (write_led_i),
    .write_color_i(write_color_i),
    .clearing_i   (clearing),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  rssc_back #(
    .MAX_SLICES(MAX_SLICES),
    .LED_COUNT (LED_COUNT),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .slices_i   (slices_q),
    .clearing_o (clearing),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata),
    .oq_count_i (oq_count),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Polar image store, slice-major: address = slice * LED_COUNT + led.
  rssc_ram #(
    .WIDTH(24),
    .DEPTH(STORE_DEPTH)
  ) u_image (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Result queue; the back end never pushes without room for it.
  rssc_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(OQ_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .wdata_i(res),
    .full_o (),
    .pop_i  (pop),
    .rdata_o(res_head),
    .empty_o(empty),
    .count_o(oq_count)
  );

  assign led_index_o   = res_head.led_index;
  assign pixel_color_o = res_head.pixel_color;
  assign shown_slice_o = res_head.shown_slice;
  assign is_blank_o    = res_head.is_blank;
  assign run_last_o    = res_head.run_last;

endmodule

### sim/rotation_synced_slice_scanner_tb.sv
// Self-checking testbench for the rotation synced slice scanner top level.
module rotation_synced_slice_scanner_tb import rssc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // kind code the block must ignore
  localparam logic [1:0] KIND_SPARE = 2'd3;
  // quiet cycles after the last expected pixel: covers two queued requests
  // plus one in the divider, even when none of them produces a run
  localparam int HOLD_OFF   = 100;
  // cycles with no accepted request or pixel before giving up; the
  // limit also covers the post-reset sweep of the image store
  localparam int STALL_LIMIT = 6000;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        push          = 1'b0;
  logic        full;
  logic [1:0]  kind_i        = KIND_TICK;
  logic [5:0]  write_slice_i = '0;
  logic [4:0]  write_led_i   = '0;
  logic [23:0] write_color_i = '0;
  logic        cfg_we_i      = 1'b0;
  logic [6:0]  cfg_wdata_i   = '0;
  logic        empty;
  logic        pop           = 1'b0;
  logic [4:0]  led_index_o;
  logic [23:0] pixel_color_o;
  logic [5:0]  shown_slice_o;
  logic        is_blank_o;
  logic        run_last_o;

  rotation_synced_slice_scanner uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .kind_i        (kind_i),
    .write_slice_i (write_slice_i),
    .write_led_i   (write_led_i),
    .write_color_i (write_color_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .empty         (empty),
    .pop           (pop),
    .led_index_o   (led_index_o),
    .pixel_color_o (pixel_color_o),
    .shown_slice_o (shown_slice_o),
    .is_blank_o    (is_blank_o),
    .run_last_o    (run_last_o)
  );

  // ---------------------------------------------------------------------
  // Own copy of the scanner state, updated on every accepted request
  // ---------------------------------------------------------------------
  logic [6:0]  slice_setting;
  logic [31:0] rot_now;
  logic [31:0] rot_last_edge;
  logic [31:0] rot_period;
  logic        strip_shown;
  logic [5:0]  strip_slice;
  logic [23:0] polar_image [MAX_SLICES_DEF*LED_COUNT_DEF];

  res_t expected_pixels [$];

  int mismatches   = 0;
  int send_idle    = 32;   // percentage of cycles the sender holds off
  int recv_idle    = 58;   // percentage of cycles the receiver stalls
  int stall_cycles = 0;

  initial begin
    slice_setting = SLICES_RESET;
    rot_now       = '0;
    rot_last_edge = '0;
    rot_period    = '0;
    strip_shown   = 1'b0;
    strip_slice   = '0;
    foreach (polar_image[i]) polar_image[i] = '0;
  end

  // One run of LED_COUNT pixels; a blank run carries no colour and slice 0.
  function automatic void queue_run(input logic [5:0] slice, input logic blank);
    res_t px;
    for (int i = 0; i < LED_COUNT_DEF; i++) begin
      px.led_index   = 5'(i);
      px.pixel_color = blank ? 24'd0 : polar_image[int'(slice)*LED_COUNT_DEF + i];
      px.shown_slice = blank ? 6'd0 : slice;
      px.is_blank    = blank;
      px.run_last    = (i == LED_COUNT_DEF - 1);
      expected_pixels.push_back(px);
    end
  endfunction

  // Angular position after a tick or an edge.
  function automatic void evaluate_rotation();
    logic [31:0] elapsed;
    logic [63:0] slice_q;
    int          eff;
    if (rot_period == 0) return;      // no full rotation seen yet
    elapsed = rot_now - rot_last_edge;
    if (elapsed >= rot_period) begin
      // rotation stopped: blank the strip once
      if (strip_shown) begin
        strip_shown = 1'b0;
        queue_run(6'd0, 1'b1);
      end
      return;
    end
    eff = (int'(slice_setting) > MAX_SLICES_DEF) ? MAX_SLICES_DEF : int'(slice_setting);
    if (eff == 0) return;
    slice_q = (64'(elapsed) * 64'(eff)) / 64'(rot_period);
    if (slice_q >= 64'(eff)) return;
    if (strip_shown && slice_q[5:0] == strip_slice) return;
    strip_shown = 1'b1;
    strip_slice = slice_q[5:0];
    queue_run(strip_slice, 1'b0);
  endfunction

  function automatic void predict_request(input logic [1:0] k, input logic [5:0] s,
                                          input logic [4:0] l, input logic [23:0] c);
    case (k)
      KIND_TICK: begin
        rot_now = rot_now + 32'd1;
        evaluate_rotation();
      end
      KIND_EDGE: begin
        rot_period    = rot_now - rot_last_edge;
        rot_last_edge = rot_now;
        evaluate_rotation();
      end
      KIND_WRITE: polar_image[int'(s)*LED_COUNT_DEF + int'(l)] = c;
      default: ;                       // spare kind: ignored
    endcase
  endfunction

  function automatic void check_pixel();
    res_t want;
    if (expected_pixels.size() == 0) begin
      $error("unexpected pixel: led_index %0d colour %06h", led_index_o, pixel_color_o);
      mismatches++;
      return;
    end
    want = expected_pixels.pop_front();
    if (led_index_o !== want.led_index) begin
      $error("led_index: expected %0d, got %0d", want.led_index, led_index_o);
      mismatches++;
    end
    if (pixel_color_o !== want.pixel_color) begin
      $error("pixel_color: expected %06h, got %06h", want.pixel_color, pixel_color_o);
      mismatches++;
    end
    if (shown_slice_o !== want.shown_slice) begin
      $error("shown_slice: expected %0d, got %0d", want.shown_slice, shown_slice_o);
      mismatches++;
    end
    if (is_blank_o !== want.is_blank) begin
      $error("is_blank: expected %0b, got %0b", want.is_blank, is_blank_o);
      mismatches++;
    end
    if (run_last_o !== want.run_last) begin
      $error("run_last: expected %0b, got %0b", want.run_last, run_last_o);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Clock, receiver, monitor and watchdog
  // ---------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver stalls at random, rate set per phase
  always @(posedge clk_i) pop <= ($urandom_range(99) >= recv_idle);

  // everything here samples the values from before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) slice_setting = cfg_wdata_i;
      if (push && !full) predict_request(kind_i, write_slice_i, write_led_i, write_color_i);
      if (pop && !empty) check_pixel();
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      stall_cycles = 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[rotation_synced_slice_scanner] ERROR");
      $finish;
    end else begin
      stall_cycles++;
    end
  end

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------
  // Offers one request and returns just after the edge that took it; push
  // stays high so back-to-back requests need no extra assignment.
  task automatic push_request(input logic [1:0] k, input logic [5:0] s,
                              input logic [4:0] l, input logic [23:0] c);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    kind_i        <= k;
    write_slice_i <= s;
    write_led_i   <= l;
    write_color_i <= c;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic push_tick();
    push_request(KIND_TICK, 6'($urandom), 5'($urandom), 24'($urandom));
  endtask

  task automatic push_edge();
    push_request(KIND_EDGE, 6'($urandom), 5'($urandom), 24'($urandom));
  endtask

  // Holds the sender off until every predicted pixel is out and the back end
  // has had time to finish requests that produce nothing.
  task automatic wait_results_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (HOLD_OFF) @(posedge clk_i);
  endtask

  task automatic write_slice_count(input logic [6:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Zero period, ignored kind, first slice, blanking once, zero-period edge.
  task automatic test_startup_sequence();
    write_slice_count(SLICES_RESET);
    push_tick();                                    // period still zero
    push_request(KIND_SPARE, 6'h3F, 5'h1F, 24'hFFFFFF);
    push_request(KIND_WRITE, 6'd0, 5'd0, 24'hFFFFFF);
    push_request(KIND_WRITE, 6'd0, 5'd31, 24'h000000);
    push_request(KIND_WRITE, 6'd10, 5'd7, 24'hA5A5A5);
    push_request(KIND_WRITE, 6'd63, 5'd31, 24'h5A5A5A);
    push_edge();                                    // period 1, slice 0 run
    push_tick();                                    // elapsed reaches period: blank
    push_tick();                                    // already blank: nothing
    push_edge();                                    // period 2, slice 0 again
    push_tick();                                    // slice 10
    push_edge();                                    // back to slice 0
    push_edge();                                    // no time since: period zero
    push_tick();
  endtask

  // One slice (repeats suppressed), no slices, and a count above the maximum.
  task automatic test_slice_count_extremes();
    wait_results_drained();
    write_slice_count(7'd1);
    push_edge();
    push_tick();
    push_tick();
    push_edge();                                    // period 2, slice 0 again
    push_tick();
    push_tick();
    push_tick();                                    // already blank: nothing
    wait_results_drained();
    write_slice_count(7'd0);
    push_edge();
    push_tick();
    wait_results_drained();
    write_slice_count(7'd127);                      // saturates to the maximum
    push_edge();
    push_tick();
    push_tick();
  endtask

  // Mostly clean rotations with random period and pixel writes between
  // ticks, sometimes running over the period; the rest is loose noise.
  task automatic test_random_rotation(input int s_idle, input int r_idle,
                                      input logic [6:0] slices, input int n_req);
    int sent;
    int period_len;
    int overrun;
    logic [1:0] k;
    wait_results_drained();
    write_slice_count(slices);
    send_idle = s_idle;
    recv_idle = r_idle;
    sent = 0;
    while (sent < n_req) begin
      if ($urandom_range(99) < 80) begin
        period_len = ($urandom_range(9) == 0) ? $urandom_range(25, 90) : $urandom_range(1, 20);
        push_edge();
        sent++;
        for (int j = 0; j < period_len && sent < n_req; j++) begin
          if ($urandom_range(99) < 20) begin
            push_request(KIND_WRITE, 6'($urandom), 5'($urandom), 24'($urandom));
            sent++;
          end
          push_tick();
          sent++;
        end
        if (sent < n_req && $urandom_range(99) < 30) begin
          overrun = $urandom_range(1, 3);
          repeat (overrun) push_tick();
          sent += overrun;
        end
      end else begin
        k = 2'($urandom_range(3));
        push_request(k, 6'($urandom), 5'($urandom), 24'($urandom));
        if (k != KIND_SPARE) sent++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_startup_sequence();
    test_slice_count_extremes();
    test_random_rotation(32, 58, 7'd64, 65);
    test_random_rotation(58, 32, 7'($urandom_range(2, 63)), 65);
    test_random_rotation(0, 0, 7'($urandom_range(1, 64)), 64);

    wait_results_drained();
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("[rotation_synced_slice_scanner] OK");
    end else begin
      $display("[rotation_synced_slice_scanner] ERROR");
    end
    $finish;
  end

endmodule
